// ----- rtl/rlol_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlol_pkg
// Shared types and constants for the ring log offset lookup block.
// ----------------------------------------------------------------------------
package rlol_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int HANDLE_W = 32;
  localparam int SIZE_W   = 20;
  localparam int OFFS_W   = 24;
  localparam int SLOT_W   = 4;

  // Request command codes.
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_FIND = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } rlol_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic do_add;
    logic do_find;
    logic step;
    logic finish;
  } rlol_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic exhausted;
    logic hit;
  } rlol_stat_t;

endpackage

// ----- rtl/rlol_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlol_ctrl
// Request acceptance and the walk sequencer of the ring lookup.
// ----------------------------------------------------------------------------
module rlol_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               in_cmd,
  input  rlol_pkg::rlol_stat_t stat,
  output rlol_pkg::rlol_cmd_t  cmd,
  output logic               busy
);

  rlol_pkg::rlol_state_t state_r, state_nxt;
  logic                  walk_end;

  assign walk_end = stat.exhausted | stat.hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rlol_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rlol_pkg::ST_IDLE: begin
        if (start && (in_cmd == rlol_pkg::CMD_FIND)) begin
          state_nxt = rlol_pkg::ST_WALK;
        end
      end
      rlol_pkg::ST_WALK: begin
        if (walk_end) begin
          state_nxt = rlol_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rlol_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b0;
    unique case (state_r)
      rlol_pkg::ST_IDLE: begin
        cmd.do_add  = start && (in_cmd == rlol_pkg::CMD_ADD);
        cmd.do_find = start && (in_cmd == rlol_pkg::CMD_FIND);
      end
      rlol_pkg::ST_WALK: begin
        busy       = 1'b1;
        cmd.step   = !walk_end;
        cmd.finish = walk_end;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/rlol_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlol_datapath
// Slot memory, ring indices, walk registers and the result register.
// ----------------------------------------------------------------------------
module rlol_datapath #(
  parameter int DEPTH = rlol_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rlol_pkg::rlol_cmd_t           cmd,
  output rlol_pkg::rlol_stat_t          stat,
  input  logic [rlol_pkg::HANDLE_W-1:0] in_entry_handle,
  input  logic [rlol_pkg::SIZE_W-1:0]   in_entry_size,
  input  logic [rlol_pkg::OFFS_W-1:0]   in_char_offset,
  output logic                          out_valid,
  output logic                          out_found,
  output logic [rlol_pkg::SLOT_W-1:0]   out_entry_slot,
  output logic [rlol_pkg::HANDLE_W-1:0] out_found_handle,
  output logic [rlol_pkg::SIZE_W-1:0]   out_byte_offset
);

  localparam int IW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int WORDW = rlol_pkg::HANDLE_W + rlol_pkg::SIZE_W;

  logic [WORDW-1:0] mem [DEPTH];

  logic [IW-1:0] wr_idx_r, wr_idx_nxt;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt;
  logic          full_r, full_nxt;

  logic [IW-1:0]                 cur_idx_r;
  logic [CW-1:0]                 cnt_r;
  logic [rlol_pkg::OFFS_W-1:0]   rem_r;
  logic [WORDW-1:0]              rd_data_r;

  logic [IW-1:0]                 rd_addr;
  logic                          rd_en;
  logic [IW-1:0]                 cur_idx_inc;
  logic [IW:0]                   fill_diff;
  logic [CW-1:0]                 fill_cnt;
  logic [rlol_pkg::SIZE_W-1:0]   cur_len;
  logic [rlol_pkg::HANDLE_W-1:0] cur_handle;
  logic [IW+rlol_pkg::SLOT_W-1:0] slot_ext;

  logic                          out_valid_r;
  logic                          out_found_r;
  logic [rlol_pkg::SLOT_W-1:0]   out_slot_r;
  logic [rlol_pkg::HANDLE_W-1:0] out_handle_r;
  logic [rlol_pkg::SIZE_W-1:0]   out_offs_r;

  function automatic logic [IW-1:0] inc_idx(input logic [IW-1:0] i);
    inc_idx = (i == IW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  // Ring index update on an add; a full ring drops its oldest entry.
  always_comb begin
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    full_nxt   = full_r;
    if (cmd.do_add) begin
      wr_idx_nxt = inc_idx(wr_idx_r);
      if (full_r) begin
        rd_idx_nxt = inc_idx(rd_idx_r);
      end else begin
        full_nxt = (inc_idx(wr_idx_r) == rd_idx_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      full_r   <= 1'b0;
    end else begin
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      full_r   <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_add) begin
      mem[wr_idx_r] <= {in_entry_handle, in_entry_size};
    end
  end

  // The read for the next slot is issued while the current one is checked.
  assign cur_idx_inc = inc_idx(cur_idx_r);
  assign rd_addr     = cmd.do_find ? rd_idx_r : cur_idx_inc;
  assign rd_en       = cmd.do_find | cmd.step;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign fill_diff = {1'b0, wr_idx_r} + (IW + 1)'(DEPTH) - {1'b0, rd_idx_r};
  always_comb begin
    if (full_r) begin
      fill_cnt = CW'(DEPTH);
    end else if (wr_idx_r >= rd_idx_r) begin
      fill_cnt = CW'(wr_idx_r - rd_idx_r);
    end else begin
      fill_cnt = CW'(fill_diff);
    end
  end

  assign cur_handle = rd_data_r[WORDW-1:rlol_pkg::SIZE_W];
  assign cur_len    = rd_data_r[rlol_pkg::SIZE_W-1:0];

  assign stat.exhausted = (cnt_r == '0);
  assign stat.hit       = (cnt_r != '0) &&
                          ({{(rlol_pkg::OFFS_W - rlol_pkg::SIZE_W){1'b0}}, cur_len} > rem_r);

  always_ff @(posedge clk) begin
    if (cmd.do_find) begin
      cur_idx_r <= rd_idx_r;
      cnt_r     <= fill_cnt;
      rem_r     <= in_char_offset;
    end else if (cmd.step) begin
      cur_idx_r <= cur_idx_inc;
      cnt_r     <= cnt_r - 1'b1;
      rem_r     <= rem_r - rlol_pkg::OFFS_W'(cur_len);
    end
  end

  assign slot_ext = (IW + rlol_pkg::SLOT_W)'(cur_idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_found_r <= stat.hit;
      if (stat.hit) begin
        out_slot_r   <= slot_ext[rlol_pkg::SLOT_W-1:0];
        out_handle_r <= cur_handle;
        out_offs_r   <= rem_r[rlol_pkg::SIZE_W-1:0];
      end else begin
        out_slot_r   <= '0;
        out_handle_r <= '0;
        out_offs_r   <= '0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_entry_slot   = out_slot_r;
  assign out_found_handle = out_handle_r;
  assign out_byte_offset  = out_offs_r;

endmodule

// ----- rtl/ring_log_offset_lookup.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_log_offset_lookup
// Overwrite-oldest ring of handle/length entries with character offset lookup.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. An add request keeps
// busy low and gives no result. A find request raises busy and walks the
// stored entries oldest first, one slot per cycle through the registered read
// port of the slot memory, until it reaches the entry that holds the offset or
// has passed all stored entries. The result appears on the out_ ports for
// exactly one cycle, marked by out_valid, in the first cycle with busy low; a
// new request may be taken in that same cycle. The result cannot be held off,
// so the receiver must capture it when out_valid is high.
// ----------------------------------------------------------------------------
module ring_log_offset_lookup #(
  parameter int DEPTH = rlol_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_cmd,
  input  logic [rlol_pkg::HANDLE_W-1:0] in_entry_handle,
  input  logic [rlol_pkg::SIZE_W-1:0]   in_entry_size,
  input  logic [rlol_pkg::OFFS_W-1:0]   in_char_offset,
  output logic                          out_valid,
  output logic                          out_found,
  output logic [rlol_pkg::SLOT_W-1:0]   out_entry_slot,
  output logic [rlol_pkg::HANDLE_W-1:0] out_found_handle,
  output logic [rlol_pkg::SIZE_W-1:0]   out_byte_offset
);

  rlol_pkg::rlol_cmd_t  cmd;
  rlol_pkg::rlol_stat_t stat;

  rlol_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  rlol_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_entry_handle  (in_entry_handle),
    .in_entry_size    (in_entry_size),
    .in_char_offset   (in_char_offset),
    .out_valid        (out_valid),
    .out_found        (out_found),
    .out_entry_slot   (out_entry_slot),
    .out_found_handle (out_found_handle),
    .out_byte_offset  (out_byte_offset)
  );

  // A find request always starts a walk.
  a_find_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_cmd == rlol_pkg::CMD_FIND)) |=> busy)
    else $error("find request did not start a walk");

  // Each result ends a walk, so two results never come back to back.
  a_result_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) && !$past(out_valid)))
    else $error("result without a preceding walk");

  // A miss reports all result fields as zero.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |->
      ((out_entry_slot == '0) && (out_found_handle == '0) && (out_byte_offset == '0)))
    else $error("miss result carries nonzero fields");

  // Control and walk commands are mutually exclusive.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.do_add, cmd.do_find, cmd.step, cmd.finish}))
    else $error("conflicting datapath commands");

endmodule

// ----- bench/ring_log_offset_lookup_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_log_offset_lookup_tb
// Self-checking bench for the overwrite-oldest ring with offset lookup. A
// short table of directed requests covers the empty ring, the field extremes,
// zero-length entries and the wrap into overwrite mode. A long random run
// follows. Every find result is checked field by field, against a pinned
// value or a behavioral copy of the ring kept in the bench.
// ----------------------------------------------------------------------------
module ring_log_offset_lookup_tb;

  localparam int DEPTH    = rlol_pkg::DEPTH_DEF;
  localparam int HANDLE_W = rlol_pkg::HANDLE_W;
  localparam int SIZE_W   = rlol_pkg::SIZE_W;
  localparam int OFFS_W   = rlol_pkg::OFFS_W;
  localparam int SLOT_W   = rlol_pkg::SLOT_W;
  localparam int N_RANDOM = 480;
  localparam int SETTLE   = DEPTH + 8;

  typedef struct packed {
    logic                found;
    logic [SLOT_W-1:0]   slot;
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   boff;
  } lookup_res_t;

  typedef struct {
    logic                cmd;
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
    logic [OFFS_W-1:0]   offset;
    bit                  pinned;
    lookup_res_t         res;
  } request_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_cmd;
  logic [HANDLE_W-1:0] in_entry_handle;
  logic [SIZE_W-1:0]   in_entry_size;
  logic [OFFS_W-1:0]   in_char_offset;
  logic                out_valid;
  logic                out_found;
  logic [SLOT_W-1:0]   out_entry_slot;
  logic [HANDLE_W-1:0] out_found_handle;
  logic [SIZE_W-1:0]   out_byte_offset;

  ring_log_offset_lookup #(.DEPTH(DEPTH)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_entry_handle  (in_entry_handle),
    .in_entry_size    (in_entry_size),
    .in_char_offset   (in_char_offset),
    .out_valid        (out_valid),
    .out_found        (out_found),
    .out_entry_slot   (out_entry_slot),
    .out_found_handle (out_found_handle),
    .out_byte_offset  (out_byte_offset)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Behavioral copy of the ring.
  logic [HANDLE_W-1:0] ring_handle [DEPTH];
  logic [SIZE_W-1:0]   ring_len    [DEPTH];
  int                  wr_ptr = 0;
  int                  rd_ptr = 0;
  bit                  ring_full = 1'b0;

  lookup_res_t lookup_expect_q[$];
  request_t    issued_q[$];
  request_t    directed[$];
  int          errors = 0;

  task automatic ring_add(input logic [HANDLE_W-1:0] h, input logic [SIZE_W-1:0] len);
    if (ring_full) rd_ptr = (rd_ptr + 1) % DEPTH;
    ring_handle[wr_ptr] = h;
    ring_len[wr_ptr] = len;
    wr_ptr = (wr_ptr + 1) % DEPTH;
    if (wr_ptr == rd_ptr) ring_full = 1'b1;
  endtask

  function automatic lookup_res_t ring_find(input logic [OFFS_W-1:0] offset);
    lookup_res_t       r;
    logic [OFFS_W-1:0] left;
    int                idx;
    int                count;
    r = '0;
    left = offset;
    idx = rd_ptr;
    count = ring_full ? DEPTH : (wr_ptr + DEPTH - rd_ptr) % DEPTH;
    for (int n = 0; n < count; n++) begin
      // Zero-length entries can never satisfy this and are stepped over.
      if (ring_len[idx] > left) begin
        r.found  = 1'b1;
        r.slot   = idx[SLOT_W-1:0];
        r.handle = ring_handle[idx];
        r.boff   = left[SIZE_W-1:0];
        return r;
      end
      left = left - ring_len[idx];
      idx = (idx + 1) % DEPTH;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    lookup_res_t want;
    request_t    row;
    if (rst_n) begin
      if (out_valid) begin
        if (lookup_expect_q.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, actual %h",
                   $time, {out_found, out_entry_slot, out_found_handle, out_byte_offset});
          errors++;
        end else begin
          want = lookup_expect_q.pop_front();
          check_field("found", 32'(want.found), 32'(out_found));
          check_field("entry_slot", 32'(want.slot), 32'(out_entry_slot));
          check_field("found_handle", want.handle, out_found_handle);
          check_field("byte_offset", 32'(want.boff), 32'(out_byte_offset));
        end
      end
      if (start && !busy) begin
        row = issued_q.pop_front();
        if (in_cmd == rlol_pkg::CMD_ADD) begin
          ring_add(in_entry_handle, in_entry_size);
        end else begin
          lookup_expect_q.push_back(row.pinned ? row.res : ring_find(in_char_offset));
        end
      end
    end
  end

  function automatic request_t make_req(input logic cmd, input logic [HANDLE_W-1:0] h,
                                        input logic [SIZE_W-1:0] size,
                                        input logic [OFFS_W-1:0] offset);
    request_t r;
    r.cmd    = cmd;
    r.handle = h;
    r.size   = size;
    r.offset = offset;
    r.pinned = 1'b0;
    r.res    = '0;
    return r;
  endfunction

  function automatic request_t pinned_find(input logic [OFFS_W-1:0] offset,
                                           input lookup_res_t res);
    request_t r;
    r = make_req(rlol_pkg::CMD_FIND, '0, '0, offset);
    r.pinned = 1'b1;
    r.res = res;
    return r;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int       pick;
    r = make_req(($urandom_range(99) < 55) ? rlol_pkg::CMD_ADD : rlol_pkg::CMD_FIND,
                 $urandom(), '0, '0);
    pick = $urandom_range(99);
    if (pick < 10)      r.size = '0;
    else if (pick < 70) r.size = SIZE_W'($urandom_range(1, 63));
    else if (pick < 90) r.size = SIZE_W'($urandom_range(64, 4095));
    else                r.size = SIZE_W'($urandom_range(0, (1 << SIZE_W) - 1));
    pick = $urandom_range(99);
    if (pick < 70)      r.offset = OFFS_W'($urandom_range(0, 1200));
    else if (pick < 85) r.offset = OFFS_W'($urandom_range(0, 70000));
    else                r.offset = OFFS_W'($urandom_range(0, (1 << OFFS_W) - 1));
    return r;
  endfunction

  // Presents one request and returns at the edge that accepts it.
  task automatic send(input request_t row);
    issued_q.push_back(row);
    start           <= 1'b1;
    in_cmd          <= row.cmd;
    in_entry_handle <= row.handle;
    in_entry_size   <= row.size;
    in_char_offset  <= row.offset;
    do @(posedge clk); while (!(start && !busy));
  endtask

  task automatic maybe_idle(input bit quiet);
    if (!quiet && $urandom_range(99) < 36) begin
      start <= 1'b0;
      if ($urandom_range(9) == 0) repeat ($urandom_range(4, 20)) @(posedge clk);
      else repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_cmd          = rlol_pkg::CMD_ADD;
    in_entry_handle = '0;
    in_entry_size   = '0;
    in_char_offset  = '0;

    // Empty ring, then the extremes of handle, size and offset.
    directed.push_back(pinned_find(24'h000000, '{1'b0, '0, '0, '0}));
    directed.push_back(pinned_find(24'hFFFFFF, '{1'b0, '0, '0, '0}));
    directed.push_back(make_req(rlol_pkg::CMD_ADD, 32'hFFFF_FFFF, 20'hFFFFF, '0));
    directed.push_back(make_req(rlol_pkg::CMD_ADD, 32'h0000_0000, 20'h00000, '0));
    directed.push_back(pinned_find(24'h000000, '{1'b1, 4'd0, 32'hFFFF_FFFF, 20'h00000}));
    directed.push_back(pinned_find(24'h0FFFFE, '{1'b1, 4'd0, 32'hFFFF_FFFF, 20'hFFFFE}));
    directed.push_back(pinned_find(24'h0FFFFF, '{1'b0, '0, '0, '0}));
    directed.push_back(pinned_find(24'hFFFFFF, '{1'b0, '0, '0, '0}));
    // Fill the ring; the last of these makes it full.
    for (int i = 0; i < DEPTH - 2; i++) begin
      directed.push_back(make_req(rlol_pkg::CMD_ADD, 32'hA5A5_0000 + 32'(i),
                                  SIZE_W'(i + 1), '0));
    end
    directed.push_back(make_req(rlol_pkg::CMD_FIND, '0, '0, 24'h100005));
    // One more add overwrites the oldest entry.
    directed.push_back(make_req(rlol_pkg::CMD_ADD, 32'h5A5A_5A5A, 20'd7, '0));
    directed.push_back(make_req(rlol_pkg::CMD_FIND, '0, '0, 24'h000000));
    directed.push_back(make_req(rlol_pkg::CMD_FIND, '0, '0, 24'd110));
    directed.push_back(make_req(rlol_pkg::CMD_FIND, '0, '0, 24'hFFFFFF));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      send(directed[i]);
      maybe_idle(1'b0);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      send(random_request());
      // The last request is followed by the final deassertion of start below.
      maybe_idle((i >= 200 && i < 320) || (i == N_RANDOM - 1));
    end
    start <= 1'b0;

    @(posedge clk);
    while (lookup_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
